>>> rtl/fcmvp_pkg.sv
// Shared types and codes for the finite-context-method value predictor.
`default_nettype none

package fcmvp_pkg;

   localparam int VALUE_WIDTH = 64;

   // Input kind codes carried in req_tuser.
   localparam logic ACT_LOOKUP = 1'b0;
   localparam logic ACT_UPDATE = 1'b1;

   // Classified command as it sits in the queue between front and back.
   typedef struct packed {
      logic                   action;
      logic                   step_down;
      logic [VALUE_WIDTH-1:0] value;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ROW,
      ST_VALUE
   } back_state_type;

endpackage

`default_nettype wire

>>> rtl/fcmvp_front.sv
// Front end: accepts request transfers, classifies them and queues commands.
`default_nettype none

module fcmvp_front #(
   parameter int HISTORY_ENTRIES = 1024
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output      logic                          req_tready,
   input  wire logic [135:0]                  req_tdata,
   input  wire logic                          req_tuser,
   input  wire logic                          clearing,
   input  wire logic                          pop,
   output      logic                          head_valid,
   output      fcmvp_pkg::cmd_type            head_cmd,
   output      logic [$clog2(HISTORY_ENTRIES)-1:0] head_entry
);

   localparam int HIDX = $clog2(HISTORY_ENTRIES);

   fcmvp_pkg::cmd_type  q_cmd_ff   [2];
   logic [HIDX-1:0]     q_entry_ff [2];
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   logic [1:0]          cnt_ff, cnt_in;
   logic                enq;
   fcmvp_pkg::cmd_type  new_cmd;

   assign req_tready = (cnt_ff != 2'd2) && !clearing;
   assign enq        = req_tvalid && req_tready;

   // Training direction is resolved here so the back end only sees one flag.
   always_comb begin
      new_cmd.action    = req_tuser;
      new_cmd.step_down = req_tdata[64] && !req_tdata[65];
      new_cmd.value     = req_tdata[129:66];
   end

   assign head_valid = (cnt_ff != 2'd0);
   assign head_cmd   = q_cmd_ff[rd_ptr_ff];
   assign head_entry = q_entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = enq ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      case ({enq, pop})
         2'b10:   cnt_in = cnt_ff + 2'd1;
         2'b01:   cnt_in = cnt_ff - 2'd1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         q_cmd_ff[wr_ptr_ff]   <= new_cmd;
         q_entry_ff[wr_ptr_ff] <= req_tdata[HIDX-1:0];
      end
   end

endmodule

`default_nettype wire

>>> rtl/fcmvp_back.sv
// Back end: table memories, clearing sweep and the lookup/update sequencer.
`default_nettype none

module fcmvp_back #(
   parameter int HISTORY_LENGTH  = 4,
   parameter int HISTORY_ENTRIES = 1024,
   parameter int VALUE_ENTRIES   = 1024,
   parameter int COUNTER_BITS    = 2
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               head_valid,
   input  wire fcmvp_pkg::cmd_type                 head_cmd,
   input  wire logic [$clog2(HISTORY_ENTRIES)-1:0] head_entry,
   output      logic                               pop,
   output      logic                               clearing,
   output      logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   output      logic [63:0]                        rsp_tdata,
   output      logic                               rsp_tuser
);

   localparam int HIDX  = $clog2(HISTORY_ENTRIES);
   localparam int VIDX  = $clog2(VALUE_ENTRIES);
   localparam int ROW_W = HISTORY_LENGTH * VIDX;
   localparam int CLW   = (HIDX > VIDX) ? HIDX : VIDX;
   localparam int VW    = fcmvp_pkg::VALUE_WIDTH;

   // Only the low VIDX bits of a history word ever reach the hash, so the
   // history table keeps just those; word 0 (oldest) sits in the low bits.
   logic [COUNTER_BITS-1:0] ctr_mem_ff  [HISTORY_ENTRIES];
   logic [ROW_W-1:0]        hist_mem_ff [HISTORY_ENTRIES];
   logic [VW-1:0]           val_mem_ff  [VALUE_ENTRIES];

   fcmvp_pkg::back_state_type state_ff, state_in;
   logic [CLW-1:0]          clr_ff, clr_in;
   fcmvp_pkg::cmd_type      cmd_ff;
   logic [HIDX-1:0]         entry_ff;
   logic [COUNTER_BITS-1:0] ctr_q_ff;
   logic [ROW_W-1:0]        row_q_ff;
   logic [VW-1:0]           val_q_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_pred_ff;
   logic [VW-1:0]           rsp_value_ff;

   logic                    out_free;
   logic                    row_rd, val_rd, rsp_load;
   logic                    ctr_we, hist_we, val_we;
   logic [HIDX-1:0]         ctr_waddr, hist_waddr;
   logic [VIDX-1:0]         val_addr;
   logic [COUNTER_BITS-1:0] ctr_wdata, ctr_next;
   logic [ROW_W-1:0]        hist_wdata, row_shift;
   logic [VW-1:0]           val_wdata;
   logic [VIDX-1:0]         slot;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign clearing = (state_ff == fcmvp_pkg::ST_CLEAR);

   always_comb begin
      slot = '0;
      for (int i = 0; i < HISTORY_LENGTH; i++) begin
         slot ^= row_q_ff[i*VIDX +: VIDX];
      end
   end

   generate
      if (HISTORY_LENGTH == 1) begin : g_single
         assign row_shift = cmd_ff.value[VIDX-1:0];
      end else begin : g_multi
         assign row_shift = {cmd_ff.value[VIDX-1:0], row_q_ff[ROW_W-1:VIDX]};
      end
   endgenerate

   // Saturating confidence counter.
   always_comb begin
      if (cmd_ff.step_down) begin
         ctr_next = (ctr_q_ff == '0) ? ctr_q_ff : ctr_q_ff - COUNTER_BITS'(1);
      end else begin
         ctr_next = (ctr_q_ff == '1) ? ctr_q_ff : ctr_q_ff + COUNTER_BITS'(1);
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fcmvp_pkg::ST_CLEAR: begin
            if (clr_ff == {CLW{1'b1}}) state_in = fcmvp_pkg::ST_IDLE;
         end
         fcmvp_pkg::ST_IDLE: begin
            if (head_valid) state_in = fcmvp_pkg::ST_ROW;
         end
         fcmvp_pkg::ST_ROW: begin
            if (cmd_ff.action == fcmvp_pkg::ACT_LOOKUP) begin
               state_in = fcmvp_pkg::ST_VALUE;
            end else begin
               state_in = fcmvp_pkg::ST_IDLE;
            end
         end
         fcmvp_pkg::ST_VALUE: begin
            if (out_free) state_in = fcmvp_pkg::ST_IDLE;
         end
         default: state_in = fcmvp_pkg::ST_CLEAR;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      pop        = 1'b0;
      row_rd     = 1'b0;
      val_rd     = 1'b0;
      rsp_load   = 1'b0;
      ctr_we     = 1'b0;
      hist_we    = 1'b0;
      val_we     = 1'b0;
      ctr_waddr  = entry_ff;
      hist_waddr = entry_ff;
      val_addr   = slot;
      ctr_wdata  = ctr_next;
      hist_wdata = row_shift;
      val_wdata  = cmd_ff.value;
      clr_in     = clr_ff;
      unique case (state_ff)
         fcmvp_pkg::ST_CLEAR: begin
            ctr_we     = 1'b1;
            hist_we    = 1'b1;
            val_we     = 1'b1;
            ctr_waddr  = clr_ff[HIDX-1:0];
            hist_waddr = clr_ff[HIDX-1:0];
            val_addr   = clr_ff[VIDX-1:0];
            ctr_wdata  = '0;
            hist_wdata = '0;
            val_wdata  = '0;
            clr_in     = clr_ff + CLW'(1);
         end
         fcmvp_pkg::ST_IDLE: begin
            pop    = head_valid;
            row_rd = head_valid;
         end
         fcmvp_pkg::ST_ROW: begin
            if (cmd_ff.action == fcmvp_pkg::ACT_LOOKUP) begin
               val_rd = 1'b1;
            end else begin
               ctr_we  = 1'b1;
               hist_we = 1'b1;
               val_we  = 1'b1;
            end
         end
         fcmvp_pkg::ST_VALUE: begin
            rsp_load = out_free;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fcmvp_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cmd_ff   <= head_cmd;
         entry_ff <= head_entry;
      end
      if (rsp_load) begin
         rsp_pred_ff  <= ctr_q_ff[COUNTER_BITS-1];
         rsp_value_ff <= ctr_q_ff[COUNTER_BITS-1] ? val_q_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctr_we) ctr_mem_ff[ctr_waddr] <= ctr_wdata;
      if (row_rd) ctr_q_ff <= ctr_mem_ff[head_entry];
   end

   always_ff @(posedge clock) begin
      if (hist_we) hist_mem_ff[hist_waddr] <= hist_wdata;
      if (row_rd) row_q_ff <= hist_mem_ff[head_entry];
   end

   always_ff @(posedge clock) begin
      if (val_we) val_mem_ff[val_addr] <= val_wdata;
      if (val_rd) val_q_ff <= val_mem_ff[val_addr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_pred_ff;

   a_pop_needs_head: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop issued with empty queue");

   a_no_pop_in_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !pop)
      else $error("command taken during clearing sweep");

   a_row_after_pop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fcmvp_pkg::ST_ROW) |-> $past(pop))
      else $error("row stage without a fetched command");

   a_val_port: assert property (@(posedge clock) disable iff (reset)
      !(val_we && val_rd))
      else $error("value table read and written together");

   a_rsp_from_value: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == fcmvp_pkg::ST_VALUE))
      else $error("response raised outside value stage");

endmodule

`default_nettype wire

>>> rtl/fcm_value_predictor.sv
// Lookup: one response per request transfer, issued from the value state once the output is free.
// Update: no response. Both are limited by the back-end sequencer, which takes one command at a time
//   and does a registered table read, then a prediction-table access, per command.
// A 2-entry command queue lets requests be taken while a response waits.
// Reset (synchronous, active high) starts a clearing sweep that zeroes all tables;
//   req_tready stays low until it ends.
`default_nettype none

module fcm_value_predictor #(
   parameter int HISTORY_LENGTH  = 4,
   parameter int HISTORY_ENTRIES = 1024,
   parameter int VALUE_ENTRIES   = 1024,
   parameter int COUNTER_BITS    = 2
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output      logic         req_tready,
   // pc[63:0], was_predicted[64], was_correct[65], true_value[129:66], zero[135:130]
   input  wire logic [135:0] req_tdata,
   // action[0]
   input  wire logic         req_tuser,
   output      logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   // predicted_value[63:0]
   output      logic [63:0]  rsp_tdata,
   // predict[0]
   output      logic         rsp_tuser
);

   localparam int HIDX = $clog2(HISTORY_ENTRIES);

   logic                clearing;
   logic                pop;
   logic                head_valid;
   fcmvp_pkg::cmd_type  head_cmd;
   logic [HIDX-1:0]     head_entry;

   fcmvp_front #(
      .HISTORY_ENTRIES (HISTORY_ENTRIES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .clearing   (clearing),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .head_entry (head_entry)
   );

   fcmvp_back #(
      .HISTORY_LENGTH  (HISTORY_LENGTH),
      .HISTORY_ENTRIES (HISTORY_ENTRIES),
      .VALUE_ENTRIES   (VALUE_ENTRIES),
      .COUNTER_BITS    (COUNTER_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .head_entry (head_entry),
      .pop        (pop),
      .clearing   (clearing),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

>>> dv/tb_fcm_value_predictor.sv
// Self-checking testbench for the FCM value predictor: scoreboard class plus stream drivers.
`timescale 1ns / 1ps

module tb_fcm_value_predictor;

   localparam int VALUE_WIDTH  = fcmvp_pkg::VALUE_WIDTH;
   localparam int HIST_LEN     = 4;
   localparam int HIST_ENTRIES = 1024;
   localparam int VAL_ENTRIES  = 1024;
   localparam int CTR_BITS     = 2;
   localparam int STALL_LIMIT  = 10000;  // covers the clearing sweep after reset
   localparam int PHASE_ITEMS  = 425;
   localparam int MAX_REPORTS  = 10;

   typedef struct packed {
      logic                   predict;
      logic [VALUE_WIDTH-1:0] value;
   } lookup_result_type;

   class fcm_scoreboard;
      logic [CTR_BITS-1:0]    counters [HIST_ENTRIES];
      logic [VALUE_WIDTH-1:0] history [HIST_ENTRIES][HIST_LEN];
      logic [VALUE_WIDTH-1:0] slot_values [VAL_ENTRIES];
      lookup_result_type      pending_lookups [$];
      int                     mismatches;
      int                     lookups;
      int                     offered;
      int                     updates;

      function new();
         foreach (counters[e]) begin
            counters[e] = '0;
            for (int i = 0; i < HIST_LEN; i++) history[e][i] = '0;
         end
         foreach (slot_values[s]) slot_values[s] = '0;
         mismatches = 0;
         lookups    = 0;
         offered    = 0;
         updates    = 0;
      endfunction

      function int unsigned entry_of(logic [VALUE_WIDTH-1:0] addr);
         return int'(addr % HIST_ENTRIES);
      endfunction

      // XOR of the whole history of one entry, folded onto the value table
      function int unsigned hash_slot(int unsigned e);
         logic [VALUE_WIDTH-1:0] h;
         h = '0;
         for (int i = 0; i < HIST_LEN; i++) h ^= history[e][i];
         return int'(h % VAL_ENTRIES);
      endfunction

      function lookup_result_type lookup_model(logic [VALUE_WIDTH-1:0] addr);
         lookup_result_type r;
         int unsigned       e;
         e         = entry_of(addr);
         r.predict = counters[e][CTR_BITS-1];
         r.value   = r.predict ? slot_values[hash_slot(e)] : '0;
         return r;
      endfunction

      function void train_model(logic [VALUE_WIDTH-1:0] addr, logic wp, logic wc,
                                logic [VALUE_WIDTH-1:0] tv);
         int unsigned e;
         int unsigned slot;
         e    = entry_of(addr);
         slot = hash_slot(e);  // taken before the shift
         if (wp && !wc) begin
            if (counters[e] != '0) counters[e] = counters[e] - 1'b1;
         end else if (counters[e] != '1) begin
            counters[e] = counters[e] + 1'b1;
         end
         for (int i = 1; i < HIST_LEN; i++) history[e][i-1] = history[e][i];
         history[e][HIST_LEN-1] = tv;
         slot_values[slot]      = tv;
      endfunction

      function void note_input(logic act, logic [VALUE_WIDTH-1:0] addr, logic wp, logic wc,
                               logic [VALUE_WIDTH-1:0] tv);
         lookup_result_type r;
         if (act == fcmvp_pkg::ACT_LOOKUP) begin
            r = lookup_model(addr);
            pending_lookups.push_back(r);
            lookups++;
            if (r.predict) offered++;
         end else begin
            train_model(addr, wp, wc, tv);
            updates++;
         end
      endfunction

      function void check_result(logic predict, logic [VALUE_WIDTH-1:0] value);
         lookup_result_type exp_r;
         if (pending_lookups.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected response: predict=%0b value=%h", predict, value);
            return;
         end
         exp_r = pending_lookups.pop_front();
         if (predict !== exp_r.predict || value !== exp_r.value) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("mismatch: expected predict=%0b value=%h, got predict=%0b value=%h",
                        exp_r.predict, exp_r.value, predict, value);
         end
      endfunction

      function void flag_leftovers();
         while (pending_lookups.size() != 0) begin
            void'(pending_lookups.pop_front());
            mismatches++;
            if (mismatches <= MAX_REPORTS) $display("lookup response never arrived");
         end
      endfunction
   endclass

   logic         clock;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   // pc[63:0], was_predicted[64], was_correct[65], true_value[129:66], zero[135:130]
   logic [135:0] req_tdata  = '0;
   // action[0]
   logic         req_tuser  = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // predicted_value[63:0]
   logic [63:0]  rsp_tdata;
   // predict[0]
   logic         rsp_tuser;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int items_sent    = 0;
   int idle_cycles   = 0;

   logic [VALUE_WIDTH-1:0] value_pool [8];
   fcm_scoreboard board = new();

   fcm_value_predictor #(
      .HISTORY_LENGTH (HIST_LEN),
      .HISTORY_ENTRIES(HIST_ENTRIES),
      .VALUE_ENTRIES  (VAL_ENTRIES),
      .COUNTER_BITS   (CTR_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // response side: check on transfer, then pick next cycle's ready
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tuser, rsp_tdata);
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // watchdog: cycles in a row without any transfer on either side
   initial begin
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("tb_fcm_value_predictor: errors");
      $finish;
   end

   task automatic send_item(input logic act, input logic [63:0] addr, input logic wp,
                            input logic wc, input logic [63:0] tv);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {6'b0, tv, wc, wp, addr};
      do @(posedge clock); while (!req_tready);
      board.note_input(act, addr, wp, wc, tv);
      items_sent++;
   endtask

   // mostly a handful of hot entries, with random upper bits to exercise aliasing
   function automatic logic [63:0] pick_addr();
      logic [63:0] a;
      a = {$urandom, $urandom};
      if ($urandom_range(99) < 85)
         a[9:0] = $urandom_range(1) ? 10'($urandom_range(7)) : 10'(1023 - $urandom_range(7));
      return a;
   endfunction

   function automatic logic [63:0] pick_value();
      if ($urandom_range(99) < 70) return value_pool[$urandom_range(7)];
      return {$urandom, $urandom};
   endfunction

   // lookup followed by its training update, flags consistent with what was offered
   task automatic send_training_pair();
      logic [63:0]       addr;
      logic [63:0]       tv;
      lookup_result_type guess;
      addr = pick_addr();
      send_item(fcmvp_pkg::ACT_LOOKUP, addr, 1'($urandom), 1'($urandom),
                {$urandom, $urandom});
      guess = board.lookup_model(addr);
      if (guess.predict && $urandom_range(99) < 40) tv = guess.value;
      else tv = pick_value();
      send_item(fcmvp_pkg::ACT_UPDATE, addr, guess.predict,
                guess.predict && (tv == guess.value), tv);
   endtask

   initial begin
      value_pool[0] = '0;
      value_pool[1] = '1;
      for (int i = 2; i < 8; i++) value_pool[i] = {$urandom, $urandom};

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: cleared tables, counter saturation both ways, aliasing, ignored fields
      send_item(fcmvp_pkg::ACT_LOOKUP, 64'h0, 1'b1, 1'b1, '1);
      send_item(fcmvp_pkg::ACT_LOOKUP, '1, 1'b0, 1'b0, '0);
      send_item(fcmvp_pkg::ACT_UPDATE, 64'h0, 1'b1, 1'b0, '1);   // already at zero
      send_item(fcmvp_pkg::ACT_LOOKUP, 64'h0, 1'b0, 1'b0, '0);
      send_item(fcmvp_pkg::ACT_UPDATE, 64'h0, 1'b0, 1'b0, 64'h0123_4567_89ab_cdef);
      send_item(fcmvp_pkg::ACT_UPDATE, 64'h0, 1'b1, 1'b1, '1);
      send_item(fcmvp_pkg::ACT_LOOKUP, 64'h8000_0000_0000_0000, 1'b0, 1'b0, '0);
      send_item(fcmvp_pkg::ACT_UPDATE, 64'h0, 1'b0, 1'b1, '0);
      // saturates high
      send_item(fcmvp_pkg::ACT_UPDATE, 64'h4000_0000_0000_0000, 1'b0, 1'b0, '1);
      send_item(fcmvp_pkg::ACT_LOOKUP, 64'h0, 1'b1, 1'b0, '1);
      send_item(fcmvp_pkg::ACT_UPDATE, 64'h0, 1'b1, 1'b0, 64'hfedc_ba98_7654_3210);
      send_item(fcmvp_pkg::ACT_LOOKUP, 64'h0, 1'b0, 1'b1, '0);
      send_item(fcmvp_pkg::ACT_UPDATE, 64'h0, 1'b1, 1'b0, '0);
      send_item(fcmvp_pkg::ACT_LOOKUP, 64'h0, 1'b0, 1'b0, '0);   // no prediction, table nonzero
      for (int i = 0; i < 4; i++)
         send_item(fcmvp_pkg::ACT_UPDATE, '1, 1'b0, 1'b0, (i % 2) ? '1 : '0);
      send_item(fcmvp_pkg::ACT_LOOKUP, '1, 1'b1, 1'b1, '1);
      send_item(fcmvp_pkg::ACT_LOOKUP, 64'h0000_0000_0000_03ff, 1'b0, 1'b0, '0);
      send_item(fcmvp_pkg::ACT_UPDATE, 64'h7fff_ffff_ffff_fc01, 1'b1, 1'b1,
                64'h5555_5555_5555_5555);
      send_item(fcmvp_pkg::ACT_UPDATE, 64'h1, 1'b0, 1'b1, 64'haaaa_aaaa_aaaa_aaaa);
      send_item(fcmvp_pkg::ACT_UPDATE, 64'h1, 1'b1, 1'b1, 64'h5555_5555_5555_5555);
      send_item(fcmvp_pkg::ACT_LOOKUP, 64'h1, 1'b0, 1'b0, '0);

      for (int ph = 0; ph < 4; ph++) begin
         int goal;
         case (ph)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 81; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 81; end
            default: begin send_idle_pct = 20; rsp_stall_pct = 20; end
         endcase
         goal = items_sent + PHASE_ITEMS;
         while (items_sent < goal) begin
            if ($urandom_range(99) < 75) send_training_pair();
            else send_item(1'($urandom), $urandom_range(1) ? pick_addr() : {$urandom, $urandom},
                           1'($urandom), 1'($urandom), {$urandom, $urandom});
         end
      end
      req_tvalid <= 1'b0;

      while (board.pending_lookups.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      board.flag_leftovers();

      $display("covered %0d lookups (%0d offering a value) and %0d updates", board.lookups,
               board.offered, board.updates);
      $display("across four handshake pressure phases; %0d mismatches", board.mismatches);
      if (board.mismatches == 0) begin
         $display("tb_fcm_value_predictor: clean");
      end else begin
         $display("tb_fcm_value_predictor: errors");
      end
      $finish;
   end

endmodule
